[src/tablxd_pkg.sv]
// Shared types and constants for the table XOR block decryptor.
package tablxd_pkg;

  localparam int ROUNDS_DEF = 17;
  localparam int SLOTS      = 16;
  localparam int ENTRY_W    = 8;
  localparam int WORD_W     = 32;

  localparam logic [1:0] REQ_WR_TABLE  = 2'd0;
  localparam logic [1:0] REQ_WR_SUBKEY = 2'd1;
  localparam logic [1:0] REQ_DECRYPT   = 2'd2;

  typedef logic [WORD_W-1:0]             word_t;
  typedef logic [SLOTS-1:0][ENTRY_W-1:0] blk_bytes_t;
  typedef logic [SLOTS-1:0][WORD_W-1:0]  tbl_words_t;
  typedef logic [3:0][WORD_W-1:0]        key_words_t;

endpackage

[src/table_xor_block_decrypt.sv]
// A decrypt beat runs the round loop through the sixteen table banks (one registered
// read per bank per round); its result is registered at the end of the final round.
// Table and subkey loads are accepted while no decrypt runs.
// The input stalls while a decrypt runs; a finished result waits in an output register.
// Reset (rst_n, synchronous) clears control only; table and subkey memories are
// undefined until loaded.
module table_xor_block_decrypt
  import tablxd_pkg::*;
#(
  parameter int ROUNDS = ROUNDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [4:0]  in_table_round,
  input  logic [3:0]  in_table_slot,
  input  logic [7:0]  in_table_entry,
  input  logic [6:0]  in_subkey_index,
  input  logic [31:0] in_word_value,
  input  logic [63:0] in_block_low,
  input  logic [63:0] in_block_high,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_plain_low,
  output logic [63:0] out_plain_high
);

  localparam int RND_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int TAW   = RND_W + ENTRY_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic             state_r, state_nxt;
  logic [RND_W-1:0] rnd_r, rnd_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [63:0]      plain_lo_r, plain_hi_r;

  logic             in_acc, acc_dec, acc_tbl, acc_key;
  logic             last, finish, straight;
  logic             rd_en;
  logic [RND_W-1:0] rd_rnd;
  blk_bytes_t       rd_bytes, in_bytes, nbytes;
  tbl_words_t       tdata;
  key_words_t       skey;

  assign in_stall = (state_r == ST_RUN);
  assign in_acc   = in_valid & ~in_stall;
  assign acc_dec  = in_acc & (in_req_type == REQ_DECRYPT);
  assign acc_tbl  = in_acc & (in_req_type == REQ_WR_TABLE)
                    & ({1'b0, in_table_round} < 6'(ROUNDS));
  assign acc_key  = in_acc & (in_req_type == REQ_WR_SUBKEY)
                    & ({1'b0, in_subkey_index} < 8'(4 * ROUNDS));

  assign in_bytes = {in_block_high, in_block_low};

  assign last     = (rnd_r == RND_W'(ROUNDS - 1));
  assign finish   = (state_r == ST_RUN) & last & (~out_valid_r | ~out_stall);
  assign straight = (rnd_r < RND_W'(2)) | last;

  // next round's addresses come straight from this round's result bytes
  assign rd_en    = acc_dec | ((state_r == ST_RUN) & ~last);
  assign rd_rnd   = acc_dec ? '0 : rnd_r + 1'b1;
  assign rd_bytes = acc_dec ? in_bytes : nbytes;

  for (genvar s = 0; s < SLOTS; s++) begin : g_bank
    tablxd_ram #(
      .DEPTH (ROUNDS * (1 << ENTRY_W)),
      .AW    (TAW)
    ) u_tbl (
      .clk   (clk),
      .we    (acc_tbl & (in_table_slot == 4'(s))),
      .waddr ({in_table_round[RND_W-1:0], in_table_entry}),
      .wdata (in_word_value),
      .re    (rd_en),
      .raddr ({rd_rnd, rd_bytes[s]}),
      .rdata (tdata[s])
    );
  end

  for (genvar j = 0; j < 4; j++) begin : g_key
    tablxd_ram #(
      .DEPTH (ROUNDS),
      .AW    (RND_W)
    ) u_key (
      .clk   (clk),
      .we    (acc_key & (in_subkey_index[1:0] == 2'(j))),
      .waddr (in_subkey_index[RND_W+1:2]),
      .wdata (in_word_value),
      .re    (rd_en),
      .raddr (rd_rnd),
      .rdata (skey[j])
    );
  end

  tablxd_round u_round (
    .tdata    (tdata),
    .skey     (skey),
    .straight (straight),
    .nbytes   (nbytes)
  );

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    out_valid_nxt = out_valid_r & out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (acc_dec) begin
          state_nxt = ST_RUN;
          rnd_nxt   = '0;
        end
      end
      ST_RUN: begin
        if (finish) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end else if (!last) begin
          rnd_nxt = rnd_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      plain_lo_r <= nbytes[7:0];
      plain_hi_r <= nbytes[15:8];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_plain_low  = plain_lo_r;
  assign out_plain_high = plain_hi_r;

  a_dec_starts: assert property (@(posedge clk) disable iff (!rst_n)
    acc_dec |=> (state_r == ST_RUN) && (rnd_r == '0))
    else $error("decrypt beat did not start the round loop");

  a_round_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && !last |=> (state_r == ST_RUN) && (rnd_r == $past(rnd_r) + 1'b1))
    else $error("round counter skipped or stopped early");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RUN) && $past(last))
    else $error("result raised outside the final round");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !finish)
    else $error("pending result would be overwritten");

endmodule

[src/tablxd_ram.sv]
// Simple dual-port RAM, one write and one registered read per cycle.
module tablxd_ram
  import tablxd_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  word_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output word_t         rdata
);

  word_t mem [DEPTH];
  word_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds when no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/tablxd_round.sv]
// One round: XOR of four table words and a subkey per output word.
module tablxd_round
  import tablxd_pkg::*;
(
  input  tbl_words_t tdata,
  input  key_words_t skey,
  input  logic       straight,
  output blk_bytes_t nbytes
);

  key_words_t w;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      w[i] = skey[i];
      for (int k = 0; k < 4; k++) begin
        if (straight) begin
          w[i] = w[i] ^ tdata[4*i + k];
        end else begin
          w[i] = w[i] ^ tdata[4*k + ((i - k) & 3)];
        end
      end
    end
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 4; k++) begin
        nbytes[4*i + k] = w[i][8*k +: 8];
      end
    end
  end

endmodule
